FILE: hw/rtl/shmbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shadow memory bounds checker.
// Holds the microcode table of the sequencer; no dependencies.
package shmbc_pkg;

    localparam int ADDR_BITS      = 48;
    localparam int LEN_BITS       = 20;
    localparam int SHADOW_ENTRIES = 65536;
    localparam int IDX_BITS       = $clog2(SHADOW_ENTRIES);
    // chunk index of an address plus headroom for ranges past the top
    localparam int CHUNK_BITS     = ADDR_BITS - 3 + 1;
    localparam int WIN_BITS       = ADDR_BITS - 3;
    localparam int CFG_IDX_BITS   = 1;
    localparam int DATA_IN_BITS   = 72;
    localparam int DATA_OUT_BITS  = 72;

    localparam logic [ADDR_BITS-1:0] BASE_RESET     = 48'h0000_0040_0000;
    localparam logic [ADDR_BITS-1:0] LIMIT_RESET    = 48'h0000_0040_0000;
    localparam logic [ADDR_BITS-1:0] SHADOW_LO      = 48'h1000_0000_0000;
    localparam logic [ADDR_BITS-1:0] SHADOW_HI      = 48'h2000_0000_0000;
    localparam logic [7:0]           POISON_MARK    = 8'hFF;

    typedef enum logic [1:0] {
        MODE_POISON   = 2'd0,
        MODE_UNPOISON = 2'd1,
        MODE_CHECK    = 2'd2,
        MODE_NOP      = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_BASE = 1'b0,
        CFG_LOW_LIMIT   = 1'b1
    } cfg_idx_t;

    // program steps; the last step falls through to the first
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SETUP  = 3'd1,
        ST_CLAMP  = 3'd2,
        ST_FILL   = 3'd3,
        ST_TAIL   = 3'd4,
        ST_SCAN   = 3'd5,
        ST_DRAIN  = 3'd6,
        ST_FINISH = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SETUP,
        ACT_CLAMP,
        ACT_FILL,
        ACT_TAIL,
        ACT_SCAN,
        ACT_RESULT
    } act_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_ITEM,
        CND_SKIP,
        CND_IS_CHECK,
        CND_MORE,
        CND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ucw_t;

    // jump to target when cond holds, else go to the next step
    function automatic ucw_t ucode_rom(input step_t pc);
        ucw_t w;
        unique case (pc)
            ST_IDLE:   w = '{act: ACT_NONE,   cond: CND_NO_ITEM,  target: ST_IDLE};
            ST_SETUP:  w = '{act: ACT_SETUP,  cond: CND_SKIP,     target: ST_FINISH};
            ST_CLAMP:  w = '{act: ACT_CLAMP,  cond: CND_IS_CHECK, target: ST_SCAN};
            ST_FILL:   w = '{act: ACT_FILL,   cond: CND_MORE,     target: ST_FILL};
            ST_TAIL:   w = '{act: ACT_TAIL,   cond: CND_ALWAYS,   target: ST_FINISH};
            ST_SCAN:   w = '{act: ACT_SCAN,   cond: CND_MORE,     target: ST_SCAN};
            ST_DRAIN:  w = '{act: ACT_NONE,   cond: CND_NEVER,    target: ST_FINISH};
            ST_FINISH: w = '{act: ACT_RESULT, cond: CND_OUT_BUSY, target: ST_FINISH};
            default:   w = '{act: ACT_NONE,   cond: CND_NEVER,    target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/shadow_memory_bounds_checker_unit.sv
`timescale 1ns / 1ps
// Shadow memory bounds checker: microcoded sequencer, datapath and shadow store.
// Depends on shmbc_pkg.
//
// Each item poisons, unpoisons or checks a byte range against a store of one
// shadow byte per 8-byte chunk of a 64K-chunk window, and gives one result.
// After reset the store is cleared, one entry a cycle, over all 65536 entries
// while s_tready stays low; configuration writes are taken throughout. The
// sequencer walks one shadow entry a cycle: an item goes through setup and
// clamp, a fill or scan walk over its in-window chunks, a tail step (which
// writes the partial end chunk of an unpoison) or a drain step, and the finish
// step, which loads its result into the output register. An item that does
// nothing, faults on the low limit or falls in the shadow region goes from
// setup straight to the finish step. The sequencer is idle again, and takes a
// new item, only once the result is loaded. Results wait in an output
// register; the next item is taken while one is held there, and the sequencer
// then waits at its last step until the register is free.
module shadow_memory_bounds_checker_unit
    import shmbc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // address[47:0], length[67:48], is_store[68], zero pad
    input  logic [DATA_IN_BITS-1:0]  s_tdata,
    // mode[1:0]
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // fault_address[47:0], fault_length[67:48], fault_is_store[68], zero pad
    output logic [DATA_OUT_BITS-1:0] m_tdata,
    // fault
    output logic                     m_tuser,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [ADDR_BITS-1:0]     cfg_wdata
);

    logic [7:0] shadow_mem [SHADOW_ENTRIES];

    step_t                 pc_reg, pc_next;
    logic                  clr_busy_reg, clr_busy_next;
    logic [IDX_BITS-1:0]   clr_idx_reg, clr_idx_next;

    logic [WIN_BITS-1:0]   wbase_reg, wbase_next;
    logic [ADDR_BITS-1:0]  llim_reg, llim_next;

    logic [1:0]            mode_reg, mode_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic                  store_reg, store_next;

    logic [CHUNK_BITS-1:0] cnt_reg, cnt_next;
    logic [CHUNK_BITS-1:0] hi_reg, hi_next;
    logic [ADDR_BITS:0]    eaddr_reg, eaddr_next;
    logic                  fault_reg, fault_next;
    logic                  tail_ok_reg, tail_ok_next;
    logic [IDX_BITS-1:0]   tail_idx_reg, tail_idx_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [CHUNK_BITS-1:0] rd_chunk_reg, rd_chunk_next;
    logic [7:0]            rd_data_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_fault_reg, m_fault_next;
    logic [ADDR_BITS-1:0]  m_addr_reg, m_addr_next;
    logic [LEN_BITS-1:0]   m_len_reg, m_len_next;
    logic                  m_store_reg, m_store_next;

    ucw_t                  ucw;
    logic                  accept;
    logic                  cond_true;
    logic                  out_free;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_widx;
    logic [7:0]            mem_wdata;
    logic [IDX_BITS-1:0]   mem_ridx;

    logic [CHUNK_BITS-1:0] wfirst;
    logic [CHUNK_BITS-1:0] wend;
    logic [CHUNK_BITS-1:0] first_chunk;
    logic [LEN_BITS:0]     tail_sum;
    logic [LEN_BITS:0]     span;
    logic                  below;
    logic                  exempt;
    logic                  skip;
    logic                  in_range;
    logic                  more;
    logic [2:0]            tail_val;
    logic [ADDR_BITS:0]    lim;
    logic                  hit;

    assign ucw         = ucode_rom(pc_reg);
    assign s_tready    = (pc_reg == ST_IDLE) && !clr_busy_reg;
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;

    assign wfirst      = {1'b0, wbase_reg};
    assign wend        = wfirst + CHUNK_BITS'(SHADOW_ENTRIES);
    assign first_chunk = {1'b0, addr_reg[ADDR_BITS-1:3]};
    assign tail_sum    = {{(LEN_BITS-2){1'b0}}, addr_reg[2:0]} + {1'b0, len_reg};
    // unpoison stops before the partial chunk; poison and check cover it
    assign span        = (mode_reg == MODE_UNPOISON) ? (tail_sum >> 3)
                                                     : ((tail_sum + (LEN_BITS+1)'(7)) >> 3);
    assign tail_val    = addr_reg[2:0] + len_reg[2:0];
    assign below       = addr_reg < llim_reg;
    assign exempt      = (addr_reg >= SHADOW_LO) && (addr_reg < SHADOW_HI);
    assign in_range    = cnt_reg < hi_reg;
    assign more        = (cnt_reg + CHUNK_BITS'(1)) < hi_reg;

    assign lim = {rd_chunk_reg, 3'b000} + {{(ADDR_BITS-7){1'b0}}, rd_data_reg};
    assign hit = rd_valid_reg && (rd_data_reg != 8'd0)
               && (rd_data_reg[7] || (eaddr_reg > lim));

    always_comb begin
        case (mode_reg)
            MODE_POISON, MODE_UNPOISON: skip = (addr_reg == '0) || (len_reg == '0);
            MODE_CHECK:                 skip = below || exempt || (len_reg == '0);
            default:                    skip = 1'b1;
        endcase
    end

    // sequencer
    always_comb begin
        unique case (ucw.cond)
            CND_NEVER:    cond_true = 1'b0;
            CND_ALWAYS:   cond_true = 1'b1;
            CND_NO_ITEM:  cond_true = !accept;
            CND_SKIP:     cond_true = skip;
            CND_IS_CHECK: cond_true = (mode_reg == MODE_CHECK);
            CND_MORE:     cond_true = more;
            CND_OUT_BUSY: cond_true = !out_free;
            default:      cond_true = 1'b0;
        endcase
        pc_next = cond_true ? ucw.target : step_t'(pc_reg + 3'd1);
    end

    // datapath
    always_comb begin
        wbase_next    = wbase_reg;
        llim_next     = llim_reg;
        mode_next     = mode_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        store_next    = store_reg;
        cnt_next      = cnt_reg;
        hi_next       = hi_reg;
        eaddr_next    = eaddr_reg;
        fault_next    = fault_reg || hit;
        tail_ok_next  = tail_ok_reg;
        tail_idx_next = tail_idx_reg;
        rd_valid_next = 1'b0;
        rd_chunk_next = cnt_reg;
        mem_ridx      = cnt_reg[IDX_BITS-1:0] - wbase_reg[IDX_BITS-1:0];
        mem_we        = 1'b0;
        mem_widx      = cnt_reg[IDX_BITS-1:0] - wbase_reg[IDX_BITS-1:0];
        mem_wdata     = (mode_reg == MODE_POISON) ? POISON_MARK : 8'd0;
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_fault_next  = m_fault_reg;
        m_addr_next   = m_addr_reg;
        m_len_next    = m_len_reg;
        m_store_next  = m_store_reg;

        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_WINDOW_BASE: wbase_next = cfg_wdata[ADDR_BITS-1:3];
                CFG_LOW_LIMIT:   llim_next  = cfg_wdata;
                default:         ;
            endcase
        end

        if (clr_busy_reg) begin
            mem_we        = 1'b1;
            mem_widx      = clr_idx_reg;
            mem_wdata     = 8'd0;
            clr_idx_next  = clr_idx_reg + IDX_BITS'(1);
            clr_busy_next = (clr_idx_reg != '1);
        end

        if (accept) begin
            mode_next  = s_tuser;
            addr_next  = s_tdata[ADDR_BITS-1:0];
            len_next   = s_tdata[ADDR_BITS+LEN_BITS-1:ADDR_BITS];
            store_next = s_tdata[ADDR_BITS+LEN_BITS];
            fault_next = 1'b0;
        end

        unique case (ucw.act)
            ACT_NONE: ;
            ACT_SETUP: begin
                cnt_next   = first_chunk;
                hi_next    = first_chunk + {{(CHUNK_BITS-LEN_BITS-1){1'b0}}, span};
                eaddr_next = {1'b0, addr_reg} + {{(ADDR_BITS-LEN_BITS+1){1'b0}}, len_reg};
                fault_next = (mode_reg == MODE_CHECK) && below;
            end
            ACT_CLAMP: begin
                cnt_next      = (cnt_reg > wfirst) ? cnt_reg : wfirst;
                hi_next       = (hi_reg < wend) ? hi_reg : wend;
                // partial chunk after an unpoisoned run, if it lies in the window
                tail_ok_next  = (mode_reg == MODE_UNPOISON) && (tail_val != 3'd0)
                              && (hi_reg >= wfirst) && (hi_reg < wend);
                tail_idx_next = hi_reg[IDX_BITS-1:0] - wbase_reg[IDX_BITS-1:0];
            end
            ACT_FILL: begin
                mem_we   = in_range;
                cnt_next = cnt_reg + CHUNK_BITS'(1);
            end
            ACT_TAIL: begin
                mem_we    = tail_ok_reg;
                mem_widx  = tail_idx_reg;
                mem_wdata = {5'd0, tail_val};
            end
            ACT_SCAN: begin
                rd_valid_next = in_range;
                cnt_next      = cnt_reg + CHUNK_BITS'(1);
            end
            ACT_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_fault_next  = fault_reg;
                    m_addr_next   = fault_reg ? addr_reg : '0;
                    m_len_next    = fault_reg ? len_reg : '0;
                    m_store_next  = fault_reg && store_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= ST_IDLE;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            wbase_reg    <= BASE_RESET[ADDR_BITS-1:3];
            llim_reg     <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
            wbase_reg    <= wbase_next;
            llim_reg     <= llim_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        store_reg    <= store_next;
        cnt_reg      <= cnt_next;
        hi_reg       <= hi_next;
        eaddr_reg    <= eaddr_next;
        fault_reg    <= fault_next;
        tail_ok_reg  <= tail_ok_next;
        tail_idx_reg <= tail_idx_next;
        rd_chunk_reg <= rd_chunk_next;
        m_fault_reg  <= m_fault_next;
        m_addr_reg   <= m_addr_next;
        m_len_reg    <= m_len_next;
        m_store_reg  <= m_store_next;
    end

    // shadow store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            shadow_mem[mem_widx] <= mem_wdata;
        end
        rd_data_reg <= shadow_mem[mem_ridx];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_fault_reg;
    assign m_tdata  = {{(DATA_OUT_BITS-ADDR_BITS-LEN_BITS-1){1'b0}},
                       m_store_reg, m_len_reg, m_addr_reg};

endmodule
